### src/r2ntt_pkg.sv
// Shared types, constants and modular add/subtract helpers for the radix-2 NTT engine.
// Used by r2ntt_modmul, radix2_ntt_engine and the testbench; depends on nothing else.
`default_nettype none

package r2ntt_pkg;

    localparam int DATA_W             = 63;
    localparam int SUM_W              = DATA_W + 1;
    localparam int CFG_ADDR_W         = 6;
    localparam int CFG_DATA_W         = 64;
    localparam int DEFAULT_MAX_POINTS = 64;
    localparam int ROOT_LOG_CAP       = 16;

    typedef logic [DATA_W-1:0] word_t;

    typedef enum logic [2:0] {
        REG_MODULUS    = 3'd0,
        REG_FWD_ROOT   = 3'd1,
        REG_INV_ROOT   = 3'd2,
        REG_LOG_LENGTH = 3'd3,
        REG_INV_MODE   = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

    // Both operands must already be below the modulus.
    function automatic word_t add_mod(word_t a, word_t b, word_t m);
        logic [SUM_W-1:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[DATA_W-1:0];
    endfunction

    function automatic word_t sub_mod(word_t a, word_t b, word_t m);
        word_t r;
        if (a >= b) begin
            r = a - b;
        end else begin
            r = a + (m - b);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### src/radix2_ntt_engine.sv
// Top level of the radix-2 number theoretic transform engine.
// Depends on r2ntt_pkg, r2ntt_ram and r2ntt_modmul.
`default_nettype none

// The engine collects N = 2^log_length residues, one per input transfer, into a point
// store, then transforms them in place modulo the configured prime and streams the N
// results out, with m_last_result high on the final one. A forward transform takes
// natural order in and gives bit-reversed order out; an inverse transform takes
// bit-reversed order in and gives natural order out, without 1/N scaling. A modulus
// below 3 acts as 3, log_length 0 acts as 1 and values above log2(MAX_POINTS) are
// clamped. Samples and roots at or above the modulus are reduced before use.
// Register writes go through the APB port at byte address 8*i and must only be made
// while the engine is idle; they do not reset a partly filled load.
// While loading, s_ready is high and each valid sample is taken; s_ready is low from
// the transfer of the N-th sample until the last result has been taken. All
// multiplications go through a single bit-serial modular multiplier, so the transform
// time is set by the number of products: one per stage root, one per point, one per
// butterfly and one per twiddle update. The point store needs no clearing pass after
// reset.
module radix2_ntt_engine #(
    parameter int MAX_POINTS = r2ntt_pkg::DEFAULT_MAX_POINTS
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [r2ntt_pkg::CFG_ADDR_W-1:0]    paddr,
    input  wire logic [r2ntt_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic      [r2ntt_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                     pready,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire r2ntt_pkg::word_t                    s_sample_value,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output r2ntt_pkg::word_t                         m_result_value,
    output logic                                     m_last_result
);
    import r2ntt_pkg::*;

    localparam int AW          = $clog2(MAX_POINTS);
    localparam int CW          = $clog2(MAX_POINTS + 1);
    localparam int IW          = CW + 1;
    localparam int MAX_LOG_RAW = CW - 1;
    localparam int MAX_LOG     = (MAX_LOG_RAW < ROOT_LOG_CAP) ? MAX_LOG_RAW : ROOT_LOG_CAP;
    localparam int LGW         = $clog2(MAX_LOG + 1);

    typedef enum logic [4:0] {
        S_LOAD,
        S_RRED,
        S_RRED_W,
        S_SQ,
        S_SQ_W,
        S_PR_RD,
        S_PR_ST,
        S_PR_W,
        S_STAGE,
        S_BF_RDU,
        S_BF_RDV,
        S_BF_MUL,
        S_BF_MW,
        S_BF_WR2,
        S_TW,
        S_TW_W,
        S_OUT_RD,
        S_OUT_LD,
        S_OUT_WAIT
    } state_t;

    // ---------------------------------------------------------------------------
    // Configuration registers. A write lands on the access cycle of the transfer.
    // ---------------------------------------------------------------------------
    word_t     modulus_reg;
    word_t     fwd_root_reg;
    word_t     inv_root_reg;
    logic [2:0] log_len_reg;
    logic      inv_mode_reg;
    reg_idx_t  cfg_idx;
    logic      cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[5:3]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg  <= word_t'(3);
            fwd_root_reg <= word_t'(1);
            inv_root_reg <= word_t'(1);
            log_len_reg  <= 3'd6;
            inv_mode_reg <= 1'b0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_MODULUS:    modulus_reg  <= pwdata[DATA_W-1:0];
                REG_FWD_ROOT:   fwd_root_reg <= pwdata[DATA_W-1:0];
                REG_INV_ROOT:   inv_root_reg <= pwdata[DATA_W-1:0];
                REG_LOG_LENGTH: log_len_reg  <= pwdata[2:0];
                REG_INV_MODE:   inv_mode_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_MODULUS:    prdata = {1'b0, modulus_reg};
            REG_FWD_ROOT:   prdata = {1'b0, fwd_root_reg};
            REG_INV_ROOT:   prdata = {1'b0, inv_root_reg};
            REG_LOG_LENGTH: prdata = {61'd0, log_len_reg};
            REG_INV_MODE:   prdata = {63'd0, inv_mode_reg};
            default:        prdata = '0;
        endcase
    end

    // Effective modulus, length and transform size.
    word_t           m_eff;
    logic [LGW-1:0]  lg_eff;
    logic [CW-1:0]   n_eff;
    logic [IW-1:0]   n_ext;

    always_comb begin
        m_eff = (modulus_reg < word_t'(3)) ? word_t'(3) : modulus_reg;
        if (log_len_reg == 3'd0) begin
            lg_eff = LGW'(1);
        end else if (int'(log_len_reg) > MAX_LOG) begin
            lg_eff = LGW'(MAX_LOG);
        end else begin
            lg_eff = LGW'(log_len_reg);
        end
        n_eff = CW'(1) << lg_eff;
        n_ext = {1'b0, n_eff};
    end

    // ---------------------------------------------------------------------------
    // Point store and the shared multiplier.
    // ---------------------------------------------------------------------------
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    word_t         ram_wdata;
    logic [AW-1:0] ram_raddr;
    word_t         ram_rdata;

    r2ntt_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic      mul_start;
    word_t     mul_a;
    word_t     mul_b;
    mul_stat_t mul_stat;
    word_t     mul_result;

    r2ntt_modmul u_mul (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .mul_start  (mul_start),
        .mul_a      (mul_a),
        .mul_b      (mul_b),
        .mul_m      (m_eff),
        .mul_stat   (mul_stat),
        .mul_result (mul_result)
    );

    // ---------------------------------------------------------------------------
    // Sequencer. Stage roots are kept in a small register file indexed by the
    // stage number k, whose butterfly span is 2^k.
    // ---------------------------------------------------------------------------
    state_t          state_reg,  state_next;
    logic [CW-1:0]   lc_reg,     lc_next;
    logic [LGW-1:0]  k_reg,      k_next;
    logic [IW-1:0]   i_reg,      i_next;
    logic [IW-1:0]   j_reg,      j_next;
    logic [IW-1:0]   half_reg,   half_next;
    word_t           tw_reg,     tw_next;
    word_t           cur_reg,    cur_next;
    word_t           u_reg,      u_next;
    word_t           s_reg,      s_next;
    word_t           d_reg,      d_next;
    word_t           out_reg,    out_next;
    logic            last_reg,   last_next;
    logic            mvalid_reg, mvalid_next;
    word_t           sr_reg [MAX_LOG+1];
    logic            sr_we;
    logic [LGW-1:0]  sr_widx;

    logic [IW-1:0]   span;
    logic [IW-1:0]   i_hi;
    logic [IW-1:0]   i_step;
    logic [IW-1:0]   j_step;
    logic [IW-1:0]   i_inc;

    assign span   = half_reg << 1;
    assign i_hi   = i_reg + half_reg;
    assign i_step = i_reg + span;
    assign j_step = j_reg + 1'b1;
    assign i_inc  = i_reg + 1'b1;

    always_comb begin
        state_next  = state_reg;
        lc_next     = lc_reg;
        k_next      = k_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        half_next   = half_reg;
        tw_next     = tw_reg;
        cur_next    = cur_reg;
        u_next      = u_reg;
        s_next      = s_reg;
        d_next      = d_reg;
        out_next    = out_reg;
        last_next   = last_reg;
        mvalid_next = mvalid_reg;
        ram_we      = 1'b0;
        ram_waddr   = i_reg[AW-1:0];
        ram_wdata   = mul_result;
        ram_raddr   = i_reg[AW-1:0];
        mul_start   = 1'b0;
        mul_a       = word_t'(1);
        mul_b       = tw_reg;
        sr_we       = 1'b0;
        sr_widx     = k_reg;

        case (state_reg)
            S_LOAD: begin
                if (s_valid) begin
                    if (lc_reg < CW'(MAX_POINTS)) begin
                        ram_we    = 1'b1;
                        ram_waddr = lc_reg[AW-1:0];
                        ram_wdata = s_sample_value;
                        lc_next   = lc_reg + 1'b1;
                    end
                    if (lc_next >= n_eff) begin
                        state_next = S_RRED;
                    end
                end
            end
            // Reduce the selected root: 1 * root mod m.
            S_RRED: begin
                mul_start  = 1'b1;
                mul_a      = word_t'(1);
                mul_b      = inv_mode_reg ? inv_root_reg : fwd_root_reg;
                state_next = S_RRED_W;
            end
            S_RRED_W: begin
                if (mul_stat.done) begin
                    cur_next   = mul_result;
                    sr_we      = 1'b1;
                    sr_widx    = lg_eff;
                    k_next     = lg_eff;
                    state_next = S_SQ;
                end
            end
            // Each smaller stage uses the square of the next larger stage's root.
            S_SQ: begin
                if (k_reg <= LGW'(1)) begin
                    i_next     = '0;
                    state_next = S_PR_RD;
                end else begin
                    mul_start  = 1'b1;
                    mul_a      = cur_reg;
                    mul_b      = cur_reg;
                    state_next = S_SQ_W;
                end
            end
            S_SQ_W: begin
                if (mul_stat.done) begin
                    sr_we      = 1'b1;
                    sr_widx    = k_reg - 1'b1;
                    cur_next   = mul_result;
                    k_next     = k_reg - 1'b1;
                    state_next = S_SQ;
                end
            end
            // Reduce every stored point below the modulus.
            S_PR_RD: begin
                state_next = S_PR_ST;
            end
            S_PR_ST: begin
                mul_start  = 1'b1;
                mul_a      = word_t'(1);
                mul_b      = ram_rdata;
                state_next = S_PR_W;
            end
            S_PR_W: begin
                if (mul_stat.done) begin
                    ram_we = 1'b1;
                    i_next = i_inc;
                    if (i_inc == n_ext) begin
                        k_next     = inv_mode_reg ? LGW'(1) : lg_eff;
                        state_next = S_STAGE;
                    end else begin
                        state_next = S_PR_RD;
                    end
                end
            end
            S_STAGE: begin
                half_next  = IW'(1) << (k_reg - 1'b1);
                i_next     = '0;
                j_next     = '0;
                tw_next    = word_t'(1);
                state_next = S_BF_RDU;
            end
            S_BF_RDU: begin
                state_next = S_BF_RDV;
            end
            S_BF_RDV: begin
                ram_raddr  = i_hi[AW-1:0];
                u_next     = ram_rdata;
                state_next = S_BF_MUL;
            end
            // Forward multiplies the difference by the twiddle; inverse the upper point.
            S_BF_MUL: begin
                mul_start = 1'b1;
                mul_b     = tw_reg;
                if (inv_mode_reg) begin
                    mul_a = ram_rdata;
                end else begin
                    mul_a  = sub_mod(u_reg, ram_rdata, m_eff);
                    s_next = add_mod(u_reg, ram_rdata, m_eff);
                end
                state_next = S_BF_MW;
            end
            S_BF_MW: begin
                if (mul_stat.done) begin
                    ram_we = 1'b1;
                    if (inv_mode_reg) begin
                        ram_wdata = add_mod(u_reg, mul_result, m_eff);
                        d_next    = sub_mod(u_reg, mul_result, m_eff);
                    end else begin
                        ram_wdata = s_reg;
                        d_next    = mul_result;
                    end
                    state_next = S_BF_WR2;
                end
            end
            S_BF_WR2: begin
                ram_we    = 1'b1;
                ram_waddr = i_hi[AW-1:0];
                ram_wdata = d_reg;
                if ((i_step + half_reg) < n_ext) begin
                    i_next     = i_step;
                    state_next = S_BF_RDU;
                end else begin
                    state_next = S_TW;
                end
            end
            S_TW: begin
                mul_start  = 1'b1;
                mul_a      = tw_reg;
                mul_b      = sr_reg[k_reg];
                state_next = S_TW_W;
            end
            S_TW_W: begin
                if (mul_stat.done) begin
                    tw_next = mul_result;
                    if (j_step < half_reg) begin
                        j_next     = j_step;
                        i_next     = j_step;
                        state_next = S_BF_RDU;
                    end else if (inv_mode_reg ? (k_reg == lg_eff) : (k_reg == LGW'(1))) begin
                        i_next     = '0;
                        state_next = S_OUT_RD;
                    end else begin
                        k_next     = inv_mode_reg ? (k_reg + 1'b1) : (k_reg - 1'b1);
                        state_next = S_STAGE;
                    end
                end
            end
            S_OUT_RD: begin
                state_next = S_OUT_LD;
            end
            S_OUT_LD: begin
                out_next    = ram_rdata;
                last_next   = (i_inc == n_ext);
                mvalid_next = 1'b1;
                state_next  = S_OUT_WAIT;
            end
            S_OUT_WAIT: begin
                if (m_ready) begin
                    mvalid_next = 1'b0;
                    if (last_reg) begin
                        lc_next    = '0;
                        state_next = S_LOAD;
                    end else begin
                        i_next     = i_inc;
                        state_next = S_OUT_RD;
                    end
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_LOAD;
            lc_reg     <= '0;
            mvalid_reg <= 1'b0;
            last_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            lc_reg     <= lc_next;
            mvalid_reg <= mvalid_next;
            last_reg   <= last_next;
        end
        k_reg    <= k_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        half_reg <= half_next;
        tw_reg   <= tw_next;
        cur_reg  <= cur_next;
        u_reg    <= u_next;
        s_reg    <= s_next;
        d_reg    <= d_next;
        out_reg  <= out_next;
        if (sr_we) begin
            sr_reg[sr_widx] <= mul_result;
        end
    end

    assign s_ready        = (state_reg == S_LOAD);
    assign m_valid        = mvalid_reg;
    assign m_result_value = out_reg;
    assign m_last_result  = last_reg;

    // ---------------------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------------------
    a_no_load_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input accepted while a result is pending");

    a_load_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        lc_reg <= CW'(MAX_POINTS))
        else $error("load count beyond store depth");

    a_mul_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_start |-> !mul_stat.busy)
        else $error("multiplier started while busy");

    a_last_restarts_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_result) |=> (s_ready && lc_reg == '0))
        else $error("final transfer did not return to loading");

endmodule

`default_nettype wire

### src/r2ntt_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Used for the point store of the NTT engine; no package dependency.
`default_nettype none

module r2ntt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

### src/r2ntt_modmul.sv
// Bit-serial modular multiplier: one double-and-add step per cycle, MSB first.
// Depends on r2ntt_pkg for word_t, add_mod and mul_stat_t.
`default_nettype none

module r2ntt_modmul (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 mul_start,
    input  wire r2ntt_pkg::word_t     mul_a,
    input  wire r2ntt_pkg::word_t     mul_b,
    input  wire r2ntt_pkg::word_t     mul_m,
    output r2ntt_pkg::mul_stat_t      mul_stat,
    output r2ntt_pkg::word_t          mul_result
);
    import r2ntt_pkg::*;

    localparam int BIT_CW = $clog2(DATA_W);

    logic              busy_reg;
    logic              done_reg;
    logic [BIT_CW-1:0] cnt_reg;
    word_t             a_reg;
    word_t             b_reg;
    word_t             m_reg;
    word_t             r_reg;
    word_t             dbl;
    word_t             r_next;

    // The accumulator is doubled, then the multiplicand is added when the bit is set.
    always_comb begin
        dbl = add_mod(r_reg, r_reg, m_reg);
        r_next = b_reg[DATA_W-1] ? add_mod(dbl, a_reg, m_reg) : dbl;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (mul_start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= BIT_CW'(DATA_W - 1);
                a_reg    <= mul_a;
                b_reg    <= mul_b;
                m_reg    <= mul_m;
                r_reg    <= '0;
            end else if (busy_reg) begin
                r_reg   <= r_next;
                b_reg   <= b_reg << 1;
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign mul_stat.busy = busy_reg;
    assign mul_stat.done = done_reg;
    assign mul_result    = r_reg;

endmodule

`default_nettype wire

### test/testbench.sv
// Self-checking testbench for the radix2_ntt_engine radix-2 number theoretic transform.
// Depends on r2ntt_pkg and the engine RTL; drives samples and APB writes, checks each result.
`timescale 1ns / 100ps

module testbench;
    import r2ntt_pkg::*;

    typedef logic [63:0] u64;

    typedef struct {
        word_t value;
        logic  last;
    } ntt_result_t;

    localparam int  STORE_DEPTH = 64;
    localparam int  LOG_CAP     = 6;
    localparam int  CYCLE_LIMIT = 1500000;
    localparam u64  PRIME_A     = 64'd998244353;
    localparam u64  PRIME_B     = 64'h7FFF_FFFF_FFFF_FFE7;
    localparam u64  WORD_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    word_t                 s_sample_value = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    word_t                 m_result_value;
    logic                  m_last_result;

    radix2_ntt_engine u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_value (s_sample_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_value (m_result_value),
        .m_last_result  (m_last_result)
    );

    always #2 aclk = ~aclk;

    // Shadow copy of the engine's registers and of its point store.
    u64          mod_shadow  = 64'd3;
    u64          fwd_shadow  = 64'd1;
    u64          inv_shadow  = 64'd1;
    logic [2:0]  log_shadow  = 3'd6;
    logic        mode_shadow = 1'b0;
    u64          points [STORE_DEPTH];
    int          fill_count = 0;

    word_t       sample_queue [$];
    ntt_result_t transform_queue [$];
    int          failures = 0;
    int          cycle_count = 0;
    int          sent_items = 0;
    bit          quiet = 1'b0;
    bit          in_fire = 1'b0;
    int          in_gap = 0;
    int          out_gap = 0;

    // Modular arithmetic on values below the modulus, done with 64-bit sums so
    // that nothing overflows for any 63-bit modulus.
    function automatic u64 mod_add(u64 a, u64 b, u64 m);
        u64 s;
        s = a + b;
        return (s >= m) ? s - m : s;
    endfunction

    function automatic u64 mod_sub(u64 a, u64 b, u64 m);
        return (a >= b) ? a - b : a + (m - b);
    endfunction

    function automatic u64 mod_mul(u64 a, u64 b, u64 m);
        u64 r;
        r = 0;
        for (int bitpos = 62; bitpos >= 0; bitpos--) begin
            r = mod_add(r, r, m);
            if (b[bitpos]) begin
                r = mod_add(r, a, m);
            end
        end
        return r;
    endfunction

    function automatic u64 mod_pow(u64 base, int unsigned e, u64 m);
        u64 acc;
        acc = 1 % m;
        while (e != 0) begin
            if (e[0]) begin
                acc = mod_mul(acc, base, m);
            end
            base = mod_mul(base, base, m);
            e = e >> 1;
        end
        return acc;
    endfunction

    // Takes one accepted sample into the shadow store; on the N-th sample it runs the
    // transform in place and queues all N results in stored order.
    task automatic absorb_sample(word_t sample);
        int unsigned lg;
        int unsigned n;
        int unsigned span;
        int unsigned half;
        u64          m;
        u64          root;
        u64          tw;
        u64          u;
        u64          v;
        u64          roots [LOG_CAP+1];
        ntt_result_t res;
        lg = log_shadow;
        if (lg < 1) begin
            lg = 1;
        end
        if (lg > LOG_CAP) begin
            lg = LOG_CAP;
        end
        n = 1 << lg;
        m = (mod_shadow < 3) ? 64'd3 : mod_shadow;
        if (fill_count < STORE_DEPTH) begin
            points[fill_count] = {1'b0, sample};
            fill_count++;
        end
        if (fill_count < n) begin
            return;
        end
        root = (mode_shadow ? inv_shadow : fwd_shadow) % m;
        for (int k = 0; k <= lg; k++) begin
            roots[k] = mod_pow(root, n >> k, m);
        end
        for (int i = 0; i < n; i++) begin
            points[i] = points[i] % m;
        end
        if (!mode_shadow) begin
            // Decimation in frequency: widest span first, twiddle after the difference.
            for (int k = lg; k >= 1; k--) begin
                span = 1 << k;
                half = span >> 1;
                tw = 1 % m;
                for (int j = 0; j < half; j++) begin
                    for (int i = j; i + half < n; i += span) begin
                        u = points[i];
                        v = points[i+half];
                        points[i]      = mod_add(u, v, m);
                        points[i+half] = mod_mul(mod_sub(u, v, m), tw, m);
                    end
                    tw = mod_mul(tw, roots[k], m);
                end
            end
        end else begin
            // Decimation in time: narrowest span first, twiddle before the butterfly.
            for (int k = 1; k <= lg; k++) begin
                span = 1 << k;
                half = span >> 1;
                tw = 1 % m;
                for (int j = 0; j < half; j++) begin
                    for (int i = j; i + half < n; i += span) begin
                        u = points[i];
                        v = mod_mul(points[i+half], tw, m);
                        points[i]      = mod_add(u, v, m);
                        points[i+half] = mod_sub(u, v, m);
                    end
                    tw = mod_mul(tw, roots[k], m);
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            res.value = points[i][DATA_W-1:0];
            res.last  = (i == n - 1);
            transform_queue.push_back(res);
        end
        fill_count = 0;
    endtask

    // Mostly no gap, sometimes a short gap, now and then a long stall.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic u64 rand_word();
        u64 r;
        r = {$urandom, $urandom};
        return r & WORD_MAX;
    endfunction

    // Input driver: presents the next queued sample at the falling edge and holds it
    // until the transfer has happened at a rising edge.
    always @(negedge aclk) begin
        logic  nxt_valid;
        word_t nxt_data;
        nxt_valid = s_valid;
        nxt_data  = s_sample_value;
        if (in_fire) begin
            nxt_valid = 1'b0;
        end
        in_fire = 1'b0;
        if (!nxt_valid && aresetn) begin
            if (in_gap > 0) begin
                in_gap--;
            end else if (sample_queue.size() > 0) begin
                nxt_data  = sample_queue.pop_front();
                nxt_valid = 1'b1;
                in_gap    = quiet ? 0 : pick_gap();
            end
        end
        s_valid        <= nxt_valid;
        s_sample_value <= nxt_data;
    end

    // Result side back-pressure, driven at the falling edge as well.
    always @(negedge aclk) begin
        if (out_gap > 0) begin
            m_ready <= 1'b0;
            out_gap--;
        end else begin
            m_ready <= aresetn;
            if (!quiet && $urandom_range(0, 3) == 0) begin
                out_gap = pick_gap();
            end
        end
    end

    // Monitor: every input transfer feeds the predictor, every result transfer is
    // compared field by field with the oldest queued expectation.
    always @(posedge aclk) begin
        ntt_result_t exp_res;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
        if (aresetn) begin
            if (s_valid && s_ready) begin
                in_fire = 1'b1;
                absorb_sample(s_sample_value);
            end
            if (m_valid && m_ready) begin
                if (transform_queue.size() == 0) begin
                    $error("unexpected result transfer, result_value %0d", m_result_value);
                    failures++;
                end else begin
                    exp_res = transform_queue.pop_front();
                    if (m_result_value !== exp_res.value) begin
                        $error("result_value expected %0d actual %0d",
                               exp_res.value, m_result_value);
                        failures++;
                    end
                    if (m_last_result !== exp_res.last) begin
                        $error("last_result expected %0d actual %0d",
                               exp_res.last, m_last_result);
                        failures++;
                    end
                end
            end
        end
    end

    // Waits until every queued sample has been taken and every result has arrived,
    // then lets the engine settle in case the last sample started no transform.
    task automatic wait_idle();
        while (!(sample_queue.size() == 0 && !s_valid && transform_queue.size() == 0)) begin
            @(posedge aclk);
        end
        repeat (40) @(posedge aclk);
    endtask

    // APB write: setup cycle, then access cycle; the register takes the value at the
    // rising edge that ends the access cycle, since pready is always high.
    task automatic write_reg(reg_idx_t idx, u64 value);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 3'b000};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            REG_MODULUS:    mod_shadow  = value & WORD_MAX;
            REG_FWD_ROOT:   fwd_shadow  = value & WORD_MAX;
            REG_INV_ROOT:   inv_shadow  = value & WORD_MAX;
            REG_LOG_LENGTH: log_shadow  = value[2:0];
            REG_INV_MODE:   mode_shadow = value[0];
            default: ;
        endcase
    endtask

    task automatic send(u64 value);
        sample_queue.push_back(value[DATA_W-1:0]);
        sent_items++;
    endtask

    task automatic configure(u64 m, u64 fwd, u64 inv, int lg, bit mode);
        write_reg(REG_MODULUS, m);
        write_reg(REG_FWD_ROOT, fwd);
        write_reg(REG_INV_ROOT, inv);
        write_reg(REG_LOG_LENGTH, lg);
        write_reg(REG_INV_MODE, mode);
    endtask

    initial begin
        u64 m;
        u64 eff_m;
        u64 fwd;
        u64 inv;
        int lg;
        int n;
        int sets;
        int extra;
        int r;
        int phase;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part. Length two over a real prime, extreme samples, and samples
        // above the modulus that must be reduced first.
        quiet = 1'b1;
        configure(PRIME_A, PRIME_A - 1, PRIME_A - 1, 1, 1'b0);
        send(0);
        send(PRIME_A - 1);
        send(WORD_MAX);
        send(PRIME_A + 5);
        wait_idle();
        quiet = 1'b0;

        // A modulus below three acts as three, and length zero acts as length two.
        configure(0, 2, 2, 0, 1'b0);
        send(5);
        send(7);
        wait_idle();

        // Inverse mode at the largest modulus with roots at the top of the range.
        configure(WORD_MAX, WORD_MAX, WORD_MAX - 1, 2, 1'b1);
        send(WORD_MAX);
        send(0);
        send(WORD_MAX - 1);
        send(1);
        wait_idle();

        // A register write in the middle of a load: five samples toward a length of
        // eight, then the length drops to four, so the next sample completes it.
        configure(PRIME_B, rand_word(), rand_word(), 3, 1'b0);
        repeat (5) send(rand_word());
        wait_idle();
        write_reg(REG_LOG_LENGTH, 2);
        send(rand_word());
        wait_idle();

        // Random part. The first two phases take the full length (the second one via
        // a clamped length code), the rest stay mostly small to keep the run short.
        phase = 0;
        while (sent_items < 380) begin
            r = $urandom_range(0, 9);
            if (r < 4) begin
                m = PRIME_A;
            end else if (r < 6) begin
                m = PRIME_B;
            end else if (r < 7) begin
                m = $urandom_range(0, 20);
            end else if (r < 8) begin
                m = WORD_MAX;
            end else begin
                m = rand_word();
            end
            eff_m = (m < 3) ? 64'd3 : m;
            if ($urandom_range(0, 3) == 0) begin
                fwd = rand_word();
                inv = rand_word();
            end else begin
                fwd = rand_word() % eff_m;
                inv = rand_word() % eff_m;
            end
            if (phase == 0) begin
                lg = 6;
            end else if (phase == 1) begin
                lg = 7;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 5) begin
                    lg = 0;
                end else if (r < 85) begin
                    lg = $urandom_range(1, 3);
                end else if (r < 96) begin
                    lg = 4;
                end else begin
                    lg = 5;
                end
            end
            configure(m, fwd, inv, lg, (phase == 1) ? 1'b1 : 1'($urandom_range(0, 1)));
            quiet = ($urandom_range(0, 4) == 0);
            n = 1 << ((lg < 1) ? 1 : (lg > LOG_CAP) ? LOG_CAP : lg);
            sets = (n >= 16) ? 1 : $urandom_range(1, 4);
            // Now and then a phase leaves a partial load behind for the next setting.
            extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, n - 1) : 0;
            for (int i = 0; i < sets * n + extra; i++) begin
                if ($urandom_range(0, 7) == 0) begin
                    send(rand_word());
                end else begin
                    send(rand_word() % eff_m);
                end
            end
            wait_idle();
            phase++;
        end

        quiet = 1'b0;
        wait_idle();
        if (failures == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### sim.f
src/r2ntt_pkg.sv
src/r2ntt_ram.sv
src/r2ntt_modmul.sv
src/radix2_ntt_engine.sv
test/testbench.sv
